// File: rtl/core/rgba_pixel_blend_unit_defines.svh
// Assertion macros shared by the pixel blender RTL.
`ifndef RGBA_PIXEL_BLEND_UNIT_DEFINES_SVH
`define RGBA_PIXEL_BLEND_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define RPB_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Implication with a fixed delay set by the dly argument.
`define RPB_ASSERT_DLY(label, cond, dly, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##dly (prop)) \
    else $error(msg);

`endif

// File: rtl/core/rpb_pkg.sv
// Types, mode codes and divide-by-255 helpers for the pixel blender.
package rpb_pkg;

  localparam logic [2:0] MODE_OVER     = 3'd0;
  localparam logic [2:0] MODE_SET      = 3'd1;
  localparam logic [2:0] MODE_AND      = 3'd2;
  localparam logic [2:0] MODE_MULTIPLY = 3'd3;
  localparam logic [2:0] MODE_SCREEN   = 3'd4;

  localparam logic [7:0] PIX_MAX = 8'd255;

  // Number of divider stages; each one resolves two quotient bits.
  localparam int DIV_STAGES = 4;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  // Item state carried through the divider stages.
  typedef struct packed {
    logic             valid;
    logic             byp;
    logic [3:0][7:0]  bpix;
    logic [7:0]       alpha;
    logic [15:0]      dsh;
    logic [2:0][16:0] rem;
    logic [2:0][7:0]  quo;
    logic [2:0]       ovf;
  } div_t;

  // Exact floor(x / 255) for x up to 65025, by reciprocal multiplication.
  function automatic logic [7:0] div255_16(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'd32897;
    return p[30:23];
  endfunction

  // Exact floor(x / 255) for x up to 255 * 64770.
  function automatic logic [15:0] div255_24(input logic [23:0] x);
    logic [47:0] p;
    p = 48'(x) * 48'd8421505;
    return p[46:31];
  endfunction

endpackage

// File: rtl/core/rpb_front.sv
// Front pipeline: products, divide by 255, numerators and overflow check.
module rpb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  rpb_pkg::pix_in_t pix,
  input  logic [2:0]       mode,
  output rpb_pkg::div_t    dout
);

  logic [3:0][7:0] src;
  logic [3:0][7:0] dst;
  logic [7:0]      inv_sa;

  // Stage 1 registers
  logic             s1_valid;
  logic [2:0]       s1_mode;
  logic [3:0][7:0]  s1_src;
  logic [3:0][7:0]  s1_dst;
  logic [15:0]      s1_t;
  logic [2:0][15:0] s1_ssa;
  logic [2:0][15:0] s1_mul;
  logic [2:0][15:0] s1_scr;

  // Stage 2 registers
  logic             s2_valid;
  logic             s2_byp;
  logic [3:0][7:0]  s2_bpix;
  logic [7:0]       s2_oa;
  logic [2:0][15:0] s2_ssa;
  logic [2:0][23:0] s2_dt;

  // Stage 3 registers
  logic             s3_valid;
  logic             s3_byp;
  logic [3:0][7:0]  s3_bpix;
  logic [7:0]       s3_oa;
  logic [2:0][16:0] s3_num;

  logic [7:0]       oa_sum;
  logic [3:0][7:0]  bpix_next;
  logic             byp_next;

  assign src = {pix.src_alpha, pix.src_blue, pix.src_green, pix.src_red};
  assign dst = {pix.dst_alpha, pix.dst_blue, pix.dst_green, pix.dst_red};
  assign inv_sa = rpb_pkg::PIX_MAX - src[3];

  always_ff @(posedge clk) begin
    s1_mode <= mode;
    s1_src  <= src;
    s1_dst  <= dst;
    s1_t    <= 16'(dst[3]) * 16'(inv_sa);
    for (int k = 0; k < 3; k++) begin
      s1_ssa[k] <= 16'(src[k]) * 16'(src[3]);
      s1_mul[k] <= 16'(dst[k]) * 16'(src[k]);
      s1_scr[k] <= 16'(rpb_pkg::PIX_MAX - dst[k]) * 16'(rpb_pkg::PIX_MAX - src[k]);
    end
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  // Every case except partial-coverage over is settled here.
  always_comb begin
    bpix_next = s1_dst;
    byp_next  = 1'b1;
    unique case (s1_mode)
      rpb_pkg::MODE_OVER: begin
        if (s1_src[3] == 8'd0) begin
          bpix_next = s1_dst;
        end else begin
          bpix_next = s1_src;
          byp_next  = (s1_src[3] == rpb_pkg::PIX_MAX) || (s1_dst[3] == 8'd0);
        end
      end
      rpb_pkg::MODE_SET: begin
        bpix_next = s1_src;
      end
      rpb_pkg::MODE_AND: begin
        bpix_next = s1_src & s1_dst;
      end
      rpb_pkg::MODE_MULTIPLY: begin
        for (int k = 0; k < 3; k++) begin
          bpix_next[k] = rpb_pkg::div255_16(s1_mul[k]);
        end
      end
      rpb_pkg::MODE_SCREEN: begin
        for (int k = 0; k < 3; k++) begin
          bpix_next[k] = rpb_pkg::PIX_MAX - rpb_pkg::div255_16(s1_scr[k]);
        end
      end
      default: begin
        bpix_next = s1_dst;
      end
    endcase
  end

  // The sum never exceeds 255 on the partial-coverage path, the only one that uses it.
  assign oa_sum = s1_src[3] + rpb_pkg::div255_16(s1_t);

  always_ff @(posedge clk) begin
    s2_byp  <= byp_next;
    s2_bpix <= bpix_next;
    s2_oa   <= oa_sum;
    s2_ssa  <= s1_ssa;
    for (int k = 0; k < 3; k++) begin
      s2_dt[k] <= 24'(s1_dst[k]) * 24'(s1_t);
    end
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_byp  <= s2_byp;
    s3_bpix <= s2_bpix;
    s3_oa   <= s2_oa;
    for (int k = 0; k < 3; k++) begin
      s3_num[k] <= 17'(s2_ssa[k]) + 17'(rpb_pkg::div255_24(s2_dt[k]));
    end
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  // A quotient of 256 or more clamps to 255; the divider only resolves 8 bits.
  always_ff @(posedge clk) begin
    dout.byp   <= s3_byp;
    dout.bpix  <= s3_bpix;
    dout.alpha <= s3_oa;
    dout.dsh   <= {s3_oa, 8'd0};
    dout.rem   <= s3_num;
    dout.quo   <= '0;
    for (int k = 0; k < 3; k++) begin
      dout.ovf[k] <= s3_num[k] >= {1'b0, s3_oa, 8'd0};
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= s3_valid;
    end
  end

endmodule

// File: rtl/core/rpb_div_stage.sv
// One divider stage: two restoring compare-subtract steps on three channels.
module rpb_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  rpb_pkg::div_t din,
  output rpb_pkg::div_t dout
);

  rpb_pkg::div_t nxt;

  always_comb begin
    nxt = din;
    for (int s = 0; s < 2; s++) begin
      nxt.dsh = nxt.dsh >> 1;
      for (int k = 0; k < 3; k++) begin
        if (nxt.rem[k] >= {1'b0, nxt.dsh}) begin
          nxt.rem[k] = nxt.rem[k] - {1'b0, nxt.dsh};
          nxt.quo[k] = {nxt.quo[k][6:0], 1'b1};
        end else begin
          nxt.quo[k] = {nxt.quo[k][6:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= nxt;
    end
  end

endmodule

// File: rtl/core/rgba_pixel_blend_unit.sv
// Top level of the RGBA8 pixel blender: mode register, pipeline and result register.
// One pixel pair is taken every clock cycle (busy stays low) and its blended
// pixel appears on result with done high. Between start and done lie four
// arithmetic stages (products, divide by 255, numerators, overflow check),
// four stages of the color divider that resolves two quotient bits each,
// and the result register. The receiver cannot stall: each result is shown
// for one cycle only and must be taken then. The mode register is written
// through cfg_valid/cfg_ready and is always ready; write it only while no
// item is in flight.
`include "rgba_pixel_blend_unit_defines.svh"
module rgba_pixel_blend_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rpb_pkg::pix_in_t  pixels,
  output logic              done,
  output rpb_pkg::pix_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_data
);

  localparam int LATENCY = rpb_pkg::DIV_STAGES + 5;

  logic             [2:0] blend_mode;
  rpb_pkg::div_t    stg [rpb_pkg::DIV_STAGES + 1];
  rpb_pkg::div_t    last;
  logic [2:0][7:0]  color;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= rpb_pkg::MODE_OVER;
    end else if (cfg_valid && cfg_ready) begin
      blend_mode <= cfg_data;
    end
  end

  rpb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .pix      (pixels),
    .mode     (blend_mode),
    .dout     (stg[0])
  );

  for (genvar i = 0; i < rpb_pkg::DIV_STAGES; i++) begin : g_div
    rpb_div_stage u_div (
      .clk  (clk),
      .rst  (rst),
      .din  (stg[i]),
      .dout (stg[i + 1])
    );
  end

  assign last = stg[rpb_pkg::DIV_STAGES];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      color[k] = last.ovf[k] ? rpb_pkg::PIX_MAX : last.quo[k];
    end
  end

  always_ff @(posedge clk) begin
    if (last.byp) begin
      result <= {last.bpix[0], last.bpix[1], last.bpix[2], last.bpix[3]};
    end else begin
      result <= {color[0], color[1], color[2], last.alpha};
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
  end

  `RPB_ASSERT_DLY(a_accept_gives_result, start && !busy, LATENCY, done, "accepted item produced no result")
  `RPB_ASSERT_IMP(a_result_has_item, done, $past(start && !busy, LATENCY), "result without an accepted item")
  `RPB_ASSERT_IMP(a_blend_alpha_nonzero, last.valid && !last.byp, last.alpha != 8'd0, "partial blend with zero output alpha")

endmodule
